// File: design/assert_macros.svh
// Assertion macros used by the checker file cerp_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked at every clock edge, reset included.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/cerp_pkg.sv
// ----------------------------------------------------------------------------
// cerp_pkg
// Types and constants shared by the commit-edge record parser.
// ----------------------------------------------------------------------------
`default_nettype none

package cerp_pkg;

  localparam int unsigned MaxHashBytesDefault = 32;
  localparam int unsigned CountBitsDefault    = 32;
  localparam int unsigned CfgIdxBits          = 3;
  localparam int unsigned CfgDataBits         = 64;
  localparam int unsigned HashBytesMin        = 20;

  localparam logic [CfgIdxBits-1:0] CfgHashBytes   = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgQueryEnable = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgQueryWord0  = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgQueryWord1  = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgQueryWord2  = 3'd4;
  localparam logic [CfgIdxBits-1:0] CfgQueryWord3  = 3'd5;

  localparam logic [1:0] VerdictMatch     = 2'd0;
  localparam logic [1:0] VerdictNoMatch   = 2'd1;
  localparam logic [1:0] VerdictMalformed = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       record_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [31:0] pair_changes;
    logic [31:0] endpoint_count;
    logic [31:0] endpoint_offset;
  } out_item_t;

endpackage

`default_nettype wire

// File: design/cerp_core.sv
// ----------------------------------------------------------------------------
// cerp_core
// Byte-serial record parser: field sequencing, order compares, query match.
// Produces one result per record end.
// ----------------------------------------------------------------------------
`default_nettype none

module cerp_core import cerp_pkg::*; #(
  parameter int unsigned MaxHashBytes = MaxHashBytesDefault,
  parameter int unsigned CountBits    = CountBitsDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       item_valid_i,
  input  wire in_item_t   item_i,
  input  wire logic [5:0] hash_bytes_i,
  input  wire logic       query_enable_i,
  input  wire logic [255:0] query_i,
  output logic            res_valid_o,
  output out_item_t       res_o
);

  localparam int unsigned IdxBits = $clog2(MaxHashBytes);

  localparam logic [2:0] PhCount     = 3'd0;
  localparam logic [2:0] PhParent    = 3'd1;
  localparam logic [2:0] PhFlags     = 3'd2;
  localparam logic [2:0] PhChanged   = 3'd3;
  localparam logic [2:0] PhEpCount   = 3'd4;
  localparam logic [2:0] PhEndpoints = 3'd5;
  localparam logic [2:0] PhDone      = 3'd6;

  localparam logic [1:0] OrdEqual   = 2'd0;
  localparam logic [1:0] OrdGreater = 2'd1;
  localparam logic [1:0] OrdLess    = 2'd2;
  localparam logic [1:0] OrdNone    = 2'd3;

  logic [2:0]  phase_q, phase_d;
  logic [5:0]  idx_q, idx_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] edges_q, edges_d;
  logic [31:0] hashes_q, hashes_d;
  logic [1:0]  ord_q, ord_d;
  logic        qm_q, qm_d;
  logic [31:0] flags_q, flags_d;
  logic [31:0] changed_q, changed_d;
  logic [31:0] pos_q, pos_d;
  logic        found_q, found_d;
  logic        err_q, err_d;
  logic [31:0] s_chg_q, s_chg_d, s_cnt_q, s_cnt_d, s_off_q, s_off_d;

  logic [7:0] parent_mem [MaxHashBytes];
  logic [7:0] endp_mem [MaxHashBytes];
  logic [7:0] parent_rd_q;
  logic [7:0] endp_rd_q;

  logic [5:0]  hlen;
  logic [7:0]  b;
  logic [31:0] acc_sh;
  logic        word_done;
  logic        idx_ok;
  logic [IdxBits-1:0] widx;
  logic [IdxBits-1:0] ridx;
  logic [7:0]  old_byte;
  logic [7:0]  qbyte;
  logic        last_hash_byte;
  logic [1:0]  ord_new;
  logic        cnt_big;
  logic        wr_parent, wr_endp;

  always_comb begin
    if (hash_bytes_i < 6'(HashBytesMin)) begin
      hlen = 6'(HashBytesMin);
    end else if (32'(hash_bytes_i) > MaxHashBytes) begin
      hlen = 6'(MaxHashBytes);
    end else begin
      hlen = hash_bytes_i;
    end
  end

  assign b        = item_i.data_byte;
  assign acc_sh   = {acc_q[23:0], b};
  assign idx_ok   = 32'(idx_q) < MaxHashBytes;
  assign widx     = idx_q[IdxBits-1:0];
  assign ridx     = idx_d[IdxBits-1:0];
  assign old_byte = (phase_q == PhParent) ? parent_rd_q : endp_rd_q;
  assign qbyte    = (idx_q < 6'd32) ? query_i[255 - 8*idx_q[4:0] -: 8] : 8'd0;
  assign last_hash_byte = (idx_q + 6'd1) >= hlen;
  assign cnt_big  = (CountBits < 32) ? ((acc_sh >> CountBits) != 32'd0) : 1'b0;

  always_comb begin
    ord_new = ord_q;
    if (idx_ok && ord_q == OrdEqual) begin
      if (b > old_byte) begin
        ord_new = OrdGreater;
      end else if (b < old_byte) begin
        ord_new = OrdLess;
      end
    end
  end

  always_comb begin
    phase_d = phase_q; idx_d = idx_q; acc_d = acc_q; edges_d = edges_q;
    hashes_d = hashes_q; ord_d = ord_q; qm_d = qm_q; flags_d = flags_q;
    changed_d = changed_q; pos_d = pos_q; found_d = found_q; err_d = err_q;
    s_chg_d = s_chg_q; s_cnt_d = s_cnt_q; s_off_d = s_off_q;
    word_done = 1'b0;
    wr_parent = 1'b0;
    wr_endp   = 1'b0;
    if (item_valid_i && item_i.byte_valid) begin
      pos_d = pos_q + 32'd1;
      if (!err_q) begin
        if (phase_q == PhCount || phase_q == PhFlags ||
            phase_q == PhChanged || phase_q == PhEpCount) begin
          acc_d = acc_sh;
          if (idx_q >= 6'd3) begin
            word_done = 1'b1;
            idx_d = '0;
          end else begin
            idx_d = idx_q + 6'd1;
          end
        end
        unique case (phase_q)
          PhCount: begin
            if (word_done) begin
              if (acc_sh == 32'd0 || cnt_big) begin
                err_d = 1'b1;
              end else begin
                edges_d = acc_sh;
                phase_d = PhParent; idx_d = '0; ord_d = OrdNone; qm_d = 1'b1;
              end
            end
          end
          PhParent: begin
            wr_parent = idx_ok;
            ord_d = ord_new;
            if (b != qbyte) qm_d = 1'b0;
            if (last_hash_byte) begin
              if (ord_new == OrdEqual || ord_new == OrdLess) err_d = 1'b1;
              phase_d = PhFlags; idx_d = '0; acc_d = '0;
            end else begin
              idx_d = idx_q + 6'd1;
            end
          end
          PhFlags: begin
            if (word_done) begin
              flags_d = acc_sh;
              if (acc_sh[31:1] != 31'd0) err_d = 1'b1;
              phase_d = PhChanged;
            end
          end
          PhChanged: begin
            if (word_done) begin
              changed_d = acc_sh;
              phase_d = PhEpCount;
            end
          end
          PhEpCount: begin
            if (word_done) begin
              if (cnt_big) begin
                err_d = 1'b1;
              end else begin
                hashes_d = acc_sh;
                if (query_enable_i && qm_q && flags_q[0]) begin
                  found_d = 1'b1;
                  s_chg_d = changed_q; s_cnt_d = acc_sh; s_off_d = pos_q + 32'd1;
                end
                if (acc_sh == 32'd0) begin
                  edges_d = edges_q - 32'd1;
                  if (edges_q == 32'd1) begin
                    phase_d = PhDone;
                  end else begin
                    phase_d = PhParent; idx_d = '0; ord_d = OrdEqual; qm_d = 1'b1;
                  end
                end else begin
                  phase_d = PhEndpoints; idx_d = '0; ord_d = OrdNone;
                end
              end
            end
          end
          PhEndpoints: begin
            wr_endp = idx_ok;
            ord_d = ord_new;
            if (last_hash_byte) begin
              if (ord_new == OrdEqual || ord_new == OrdLess) err_d = 1'b1;
              idx_d = '0; ord_d = OrdEqual;
              hashes_d = hashes_q - 32'd1;
              if (hashes_q == 32'd1) begin
                edges_d = edges_q - 32'd1;
                if (edges_q == 32'd1) begin
                  phase_d = PhDone;
                end else begin
                  phase_d = PhParent; ord_d = OrdEqual; qm_d = 1'b1;
                end
              end
            end else begin
              idx_d = idx_q + 6'd1;
            end
          end
          default: err_d = 1'b1;
        endcase
      end
    end
  end

  // Verdict from the post-byte state, then the record state returns to reset.
  always_comb begin
    res_o = '0;
    if (err_d || phase_d != PhDone) begin
      res_o.verdict = VerdictMalformed;
    end else if (found_d) begin
      res_o.verdict         = VerdictMatch;
      res_o.pair_changes    = s_chg_d;
      res_o.endpoint_count  = s_cnt_d;
      res_o.endpoint_offset = s_off_d;
    end else begin
      res_o.verdict = VerdictNoMatch;
    end
  end
  assign res_valid_o = item_valid_i && item_i.record_last;

  // The stores are read at the index the next hash byte will use, through a
  // register, so the stored byte is waiting there when that byte arrives.
  always_ff @(posedge clk_i) begin
    if (wr_parent) parent_mem[widx] <= b;
    if (wr_endp) endp_mem[widx] <= b;
    parent_rd_q <= parent_mem[ridx];
    endp_rd_q   <= endp_mem[ridx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhCount; idx_q <= '0; acc_q <= '0; edges_q <= '0; hashes_q <= '0;
      ord_q <= OrdEqual; qm_q <= 1'b1; flags_q <= '0; changed_q <= '0; pos_q <= '0;
      found_q <= 1'b0; err_q <= 1'b0; s_chg_q <= '0; s_cnt_q <= '0; s_off_q <= '0;
    end else if (res_valid_o) begin
      phase_q <= PhCount; idx_q <= '0; acc_q <= '0; edges_q <= '0; hashes_q <= '0;
      ord_q <= OrdEqual; qm_q <= 1'b1; flags_q <= '0; changed_q <= '0; pos_q <= '0;
      found_q <= 1'b0; err_q <= 1'b0; s_chg_q <= '0; s_cnt_q <= '0; s_off_q <= '0;
    end else begin
      phase_q <= phase_d; idx_q <= idx_d; acc_q <= acc_d; edges_q <= edges_d;
      hashes_q <= hashes_d; ord_q <= ord_d; qm_q <= qm_d; flags_q <= flags_d;
      changed_q <= changed_d; pos_q <= pos_d; found_q <= found_d; err_q <= err_d;
      s_chg_q <= s_chg_d; s_cnt_q <= s_cnt_d; s_off_q <= s_off_d;
    end
  end

endmodule

`default_nettype wire

// File: design/cerp_out_buf.sv
// ----------------------------------------------------------------------------
// cerp_out_buf
// Two-entry output buffer so the parser keeps taking bytes while a verdict
// waits for the downstream side.
// ----------------------------------------------------------------------------
`default_nettype none

module cerp_out_buf import cerp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire out_item_t push_data_i,
  output logic           space_o,
  output logic           valid_o,
  input  wire logic      ready_i,
  output out_item_t      data_o
);

  out_item_t  mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rptr_q];
  // A push is only offered when a slot is free or one is leaving this cycle.
  assign space_o = (cnt_q != 2'd2) || pop;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

// File: design/commit_edge_record_parser.sv
// ----------------------------------------------------------------------------
// commit_edge_record_parser
// A streaming validator for one big-endian commit-edge record, fed one byte per
// transaction. It accepts a byte in every cycle with buffer space; each byte
// passes through the field sequencer in that cycle, and the verdict transaction
// of a record appears on the output in the cycle after its last input
// transaction, held in a two-entry buffer so input keeps flowing while the
// verdict waits. Input stalls only when both buffer entries are full.
// Configuration is taken on any cycle with cfg_we_i high.
// ----------------------------------------------------------------------------
`default_nettype none

module commit_edge_record_parser import cerp_pkg::*; #(
  parameter int unsigned MaxHashBytes = MaxHashBytesDefault,
  parameter int unsigned CountBits    = CountBitsDefault
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire in_item_t               in_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output out_item_t                   out_data_o,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  wire logic [CfgDataBits-1:0] cfg_data_i
);

  logic [5:0]   hash_bytes_q;
  logic         query_en_q;
  logic [255:0] query_q;
  logic         item_valid;
  logic         res_valid;
  out_item_t    res;
  logic         space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_bytes_q <= 6'd20;
      query_en_q   <= 1'b0;
      query_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHashBytes:   hash_bytes_q <= cfg_data_i[5:0];
        CfgQueryEnable: query_en_q <= cfg_data_i[0];
        CfgQueryWord0:  query_q[255:192] <= cfg_data_i;
        CfgQueryWord1:  query_q[191:128] <= cfg_data_i;
        CfgQueryWord2:  query_q[127:64] <= cfg_data_i;
        CfgQueryWord3:  query_q[63:0] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = space;
  assign item_valid = in_valid_i && space;

  cerp_core #(.MaxHashBytes(MaxHashBytes), .CountBits(CountBits)) u_core (
    .clk_i, .rst_ni,
    .item_valid_i(item_valid), .item_i(in_data_i),
    .hash_bytes_i(hash_bytes_q), .query_enable_i(query_en_q), .query_i(query_q),
    .res_valid_o(res_valid), .res_o(res)
  );

  cerp_out_buf u_buf (
    .clk_i, .rst_ni,
    .push_i(res_valid), .push_data_i(res), .space_o(space),
    .valid_o(out_valid_o), .ready_i(out_ready_i), .data_o(out_data_o)
  );

endmodule

`default_nettype wire

// File: design/cerp_checker.sv
// ----------------------------------------------------------------------------
// cerp_checker
// Port-level checks on the record parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cerp_checker import cerp_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire in_item_t  in_data_i,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_data_o
);

  logic verdict_ok;
  logic fields_ok;
  logic last_taken;
  logic out_stall;

  assign verdict_ok = (out_data_o.verdict == VerdictMatch) ||
                      (out_data_o.verdict == VerdictNoMatch) ||
                      (out_data_o.verdict == VerdictMalformed);
  // Only a match carries counts and an offset.
  assign fields_ok  = (out_data_o.verdict == VerdictMatch) ||
                      (out_data_o.pair_changes == 32'd0 &&
                       out_data_o.endpoint_count == 32'd0 &&
                       out_data_o.endpoint_offset == 32'd0);
  assign last_taken = in_valid_i && in_ready_o && in_data_i.record_last;
  assign out_stall  = out_valid_o && !out_ready_i;

  `CHK_ASSERT(a_verdict_code, clk_i, rst_ni, out_valid_o |-> verdict_ok, "bad verdict")
  `CHK_ASSERT(a_nomatch_zero, clk_i, rst_ni, out_valid_o |-> fields_ok, "fields not zero")
  `CHK_ASSERT(a_last_gives_out, clk_i, rst_ni, last_taken |=> out_valid_o, "verdict missing")
  `CHK_ASSERT(a_out_stable, clk_i, rst_ni, out_stall |=> (out_valid_o && $stable(out_data_o)), "output changed while stalled")
  `CHK_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !out_valid_o, "output valid in reset")

endmodule

bind commit_edge_record_parser cerp_checker u_cerp_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
  .out_valid_o, .out_ready_i, .out_data_o
);

`default_nettype wire
